// ===== hw/rtl/modexp_pkg.sv =====
package modexp_pkg;

    // Reset value of the modulus register, cut to the configured width at the top level.
    localparam logic [63:0] MODULUS_RESET = 64'd257;

    // Sequencer states of the exponentiation core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MULT,
        ST_SQUARE,
        ST_DONE
    } state_t;

    // Status of the shared modular multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// ===== hw/rtl/modexp_mulmod.sv =====
module modexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [WIDTH-1:0]        op_a,
    input  logic [WIDTH-1:0]        op_b,
    input  logic [WIDTH-1:0]        modulus,
    output modexp_pkg::mm_status_t  status,
    output logic [WIDTH-1:0]        result
);
    import modexp_pkg::*;

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] r_reg, r_next;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] mod_x1;
    logic [WIDTH+1:0] mod_x2;
    logic [WIDTH-1:0] step_r;

    // One step of MSB-first shift-and-add: r = (2r + a*bit) mod m.
    // With r, a below m the sum stays below 3m, so one of three candidates is right.
    always_comb
    begin
        mod_x1 = {2'b00, modulus};
        mod_x2 = {1'b0, modulus, 1'b0};
        sum    = {1'b0, r_reg, 1'b0} + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
        priority if (modulus == '0)
        begin
            step_r = sum[WIDTH-1:0];
        end
        else if (sum >= mod_x2)
        begin
            step_r = WIDTH'(sum - mod_x2);
        end
        else if (sum >= mod_x1)
        begin
            step_r = WIDTH'(sum - mod_x1);
        end
        else
        begin
            step_r = sum[WIDTH-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (busy_reg)
        begin
            r_next   = step_r;
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = r_reg;

endmodule

// ===== hw/rtl/modular_exponentiation_core.sv =====
// Modular exponentiation core: computes power_mod = base ^ exponent mod modulus by
// right-to-left square-and-multiply, with every product formed and reduced on one shared
// shift-and-add modular multiplier that handles one multiplier bit per cycle. The modulus
// register resets to 257 (cut to WIDTH bits); the user must write it through
// cfg_we/cfg_wdata only while the core is idle, which the core itself does not enforce.
// One transfer is taken at a time: in_stall stays high from the accepting edge until the
// result transfer completes. A zero exponent gives 1 on the cycle after the input
// transfer. Otherwise an item takes one reduction of the base, L squarings and P
// multiplies, where L is the position of the highest set exponent bit and P the number
// of set exponent bits. A modulus of zero means no reduction: the result is then
// base ^ exponent mod 2^WIDTH.
module modular_exponentiation_core #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [WIDTH-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WIDTH-1:0] base,
    input  logic [WIDTH-1:0] exponent,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] power_mod
);
    import modexp_pkg::*;

    state_t           state_reg, state_next;
    logic             issued_reg, issued_next;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] sq_reg, sq_next;
    logic [WIDTH-1:0] exp_reg, exp_next;

    logic             mm_start;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic [WIDTH-1:0] mm_result;
    mm_status_t       mm_status;

    // The shared multiplier. It forms (a * b) mod modulus, or a * b truncated when the
    // modulus is zero.
    modexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (mod_reg),
        .status  (mm_status),
        .result  (mm_result)
    );

    // Operand selection. The base is reduced as 1 * base, which steps through the bits of
    // the base and so works for any base width.
    always_comb
    begin
        unique case (state_reg)
            ST_REDUCE:
            begin
                mm_a = WIDTH'(1);
                mm_b = sq_reg;
            end
            ST_MULT:
            begin
                mm_a = acc_reg;
                mm_b = sq_reg;
            end
            ST_SQUARE:
            begin
                mm_a = sq_reg;
                mm_b = sq_reg;
            end
            default:
            begin
                mm_a = sq_reg;
                mm_b = sq_reg;
            end
        endcase
    end

    // Sequencer. Each working state first launches one multiplier operation, then waits
    // for its done pulse and moves on. Squaring stops once no set exponent bits remain.
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        mm_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    issued_next = 1'b0;
                    if (exponent == '0)
                    begin
                        acc_next   = WIDTH'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sq_next    = base;
                        exp_next   = exponent;
                        acc_next   = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE, ST_MULT, ST_SQUARE:
            begin
                if (!issued_reg)
                begin
                    mm_start    = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mm_status.done)
                begin
                    issued_next = 1'b0;
                    if (state_reg == ST_REDUCE)
                    begin
                        sq_next    = mm_result;
                        state_next = exp_reg[0] ? ST_MULT : ST_SQUARE;
                    end
                    else if (state_reg == ST_MULT)
                    begin
                        acc_next   = mm_result;
                        state_next = (exp_reg[WIDTH-1:1] == '0) ? ST_DONE : ST_SQUARE;
                    end
                    else
                    begin
                        sq_next    = mm_result;
                        exp_next   = {1'b0, exp_reg[WIDTH-1:1]};
                        state_next = exp_reg[1] ? ST_MULT : ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            mod_reg    <= MODULUS_RESET[WIDTH-1:0];
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            if (cfg_we)
            begin
                mod_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        exp_reg <= exp_next;
    end

    // The result register doubles as the output stage; it holds while out_stall is high.
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign power_mod = acc_reg;

    // The sequencer only launches an operation on an idle multiplier.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_status.busy)
        else $error("multiplier started while busy");

    // Operands stay reduced below a nonzero modulus while the loop runs.
    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MULT || state_reg == ST_SQUARE) && mod_reg != '0)
        |-> (acc_reg < mod_reg && sq_reg < mod_reg))
        else $error("operand not reduced below modulus");

    // The loop never runs with no exponent bits left.
    a_exp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULT || state_reg == ST_SQUARE) |-> (exp_reg != '0))
        else $error("exponent exhausted inside the loop");

    // A zero exponent transfer yields 1 on the next cycle.
    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && exponent == '0)
        |=> (out_valid && power_mod == WIDTH'(1)))
        else $error("zero exponent did not give one");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import modexp_pkg::*;

    localparam int W = 32;

    // Cycles without any transfer before the run is declared hung. The limit covers the
    // slowest item plus the longest stall and gap on either side.
    localparam int HANG_LIMIT = 20000;

    // Cycles to let pass after the last result before the verdict.
    localparam int DRAIN_CYCLES = 100;

    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 32;

    // One row of the directed part. When set_mod is high, the modulus is rewritten
    // (with the core idle) before the operands go in. When known is high, the result
    // is the typed value; otherwise it comes from the predictor.
    typedef struct packed {
        bit         set_mod;
        logic [W-1:0] mod_value;
        logic [W-1:0] base_v;
        logic [W-1:0] exp_v;
        bit         known;
        logic [W-1:0] want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 25;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // Reset modulus of 257.
        '{1'b0, 32'd0,          32'd0,          32'd0,          1'b1, 32'd1},
        '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'd0,          1'b1, 32'd1},
        '{1'b0, 32'd0,          32'd0,          32'd1,          1'b1, 32'd0},
        '{1'b0, 32'd0,          32'd0,          32'hFFFF_FFFF,  1'b1, 32'd0},
        '{1'b0, 32'd0,          32'd2,          32'd8,          1'b1, 32'd256},
        '{1'b0, 32'd0,          32'd256,        32'd2,          1'b1, 32'd1},
        '{1'b0, 32'd0,          32'd257,        32'd5,          1'b1, 32'd0},
        '{1'b0, 32'd0,          32'd1,          32'hFFFF_FFFF,  1'b1, 32'd1},
        '{1'b0, 32'd0,          32'd3,          32'd1,          1'b1, 32'd3},
        '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'd0},
        '{1'b0, 32'd0,          32'hDEAD_BEEF,  32'h8000_0000,  1'b0, 32'd0},
        // Modulus one: a zero exponent still gives 1, anything else gives 0.
        '{1'b1, 32'd1,          32'd5,          32'd0,          1'b1, 32'd1},
        '{1'b0, 32'd0,          32'd5,          32'd3,          1'b1, 32'd0},
        '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
        // Largest modulus.
        '{1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd7,          1'b1, 32'd0},
        '{1'b0, 32'd0,          32'hFFFF_FFFE,  32'd1,          1'b1, 32'hFFFF_FFFE},
        '{1'b0, 32'd0,          32'hFFFF_FFFE,  32'd2,          1'b1, 32'd1},
        '{1'b0, 32'd0,          32'h1234_5678,  32'hABCD_EF01,  1'b0, 32'd0},
        // Modulus zero: products just wrap to W bits.
        '{1'b1, 32'd0,          32'd3,          32'd2,          1'b1, 32'd9},
        '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'd2,          1'b1, 32'd1},
        '{1'b0, 32'd0,          32'd2,          32'd32,         1'b1, 32'd0},
        '{1'b0, 32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF},
        // Smallest modulus that reduces, then one with only the top bit set.
        '{1'b1, 32'd2,          32'd5,          32'd3,          1'b1, 32'd1},
        '{1'b0, 32'd0,          32'd4,          32'd1,          1'b1, 32'd0},
        '{1'b1, 32'h8000_0000,  32'h8000_0001,  32'd1,          1'b1, 32'd1}
    };

    logic         clk;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [W-1:0] cfg_wdata = '0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [W-1:0] base = '0;
    logic [W-1:0] exponent = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] power_mod;

    // Copy of the modulus register and the results still owed by the core, oldest first.
    logic [W-1:0] cur_modulus;
    logic [W-1:0] expected_power_mod[$];

    int  error_count = 0;
    bit  idle_on = 1'b1;
    int  stall_left = 0;

    wire in_xfer  = in_valid && !in_stall;
    wire out_xfer = out_valid && !out_stall;

    modular_exponentiation_core #(
        .WIDTH(W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .power_mod (power_mod)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Product of two reduced operands, reduced by the modulus. Both operands are below
    // 2^W, so the 64-bit product is exact. A zero modulus means plain wrap to W bits.
    function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                               logic [W-1:0] m);
        logic [63:0] prod;
        prod = a * b;
        if (m == '0)
            return prod & ((64'd1 << W) - 64'd1);
        return prod % {32'd0, m};
    endfunction

    // Right-to-left square-and-multiply over all W exponent bits.
    function automatic logic [W-1:0] compute_power_mod(logic [W-1:0] m, logic [W-1:0] b,
                                                       logic [W-1:0] e);
        logic [63:0] acc;
        logic [63:0] sq;
        if (e == '0)
            return W'(1);
        if (m != '0)
        begin
            sq  = {32'd0, b} % {32'd0, m};
            acc = 64'd1 % {32'd0, m};
        end
        else
        begin
            sq  = {32'd0, b};
            acc = 64'd1;
        end
        for (int i = 0; i < W; i++)
        begin
            if (e[i])
                acc = mul_reduce(acc, sq, m);
            sq = mul_reduce(sq, sq, m);
        end
        return acc[W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Presents one operand pair and returns at the edge where the transfer happens,
    // leaving in_valid high so the caller decides what follows in the same step.
    task automatic send_operands(input logic [W-1:0] b, input logic [W-1:0] e,
                                 input bit known, input logic [W-1:0] want);
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (in_stall);
        expected_power_mod.push_back(known ? want : compute_power_mod(cur_modulus, b, e));
    endtask

    // Optional gap on the input side, in a random burst.
    task automatic input_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // The modulus may only change while the core is idle: every owed result must be
    // back before the write goes out.
    task automatic write_modulus(input logic [W-1:0] value);
        in_valid <= 1'b0;
        while (expected_power_mod.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_modulus  = value;
    endtask

    // Output stall in random bursts; no new burst starts while idling is switched off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
            out_stall <= (stall_left > 0);
        end
    end

    // Result checker: each result transfer is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_xfer)
        begin
            if (expected_power_mod.size() == 0)
                report_mismatch($sformatf("result 0x%08h with none expected", power_mod));
            else if (power_mod !== expected_power_mod[0])
            begin
                report_mismatch($sformatf("power_mod 0x%08h, expected 0x%08h",
                                          power_mod, expected_power_mod[0]));
                void'(expected_power_mod.pop_front());
            end
            else
                void'(expected_power_mod.pop_front());
        end
    end

    // Watchdog: ends the run when no transfer happens on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (in_xfer || out_xfer)
                quiet = 0;
            else
                quiet++;
            if (quiet >= HANG_LIMIT)
                break;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [W-1:0] b;
        logic [W-1:0] e;
        logic [W-1:0] m;

        cur_modulus = MODULUS_RESET[W-1:0];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset modulus.
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            if (DIRECTED[r].set_mod)
                write_modulus(DIRECTED[r].mod_value);
            input_gap();
            send_operands(DIRECTED[r].base_v, DIRECTED[r].exp_v,
                          DIRECTED[r].known, DIRECTED[r].want);
        end

        // Random part: one modulus per phase, the last phase runs without any idling.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0, 5:    m = $urandom;
                1:       m = 32'hFFFF_FFFF;
                2:       m = $urandom_range(2, 1000);
                3:       m = 32'hFFFF_FFFB;
                4:       m = 32'd1;
                6:       m = 32'd0;
                default: m = MODULUS_RESET[W-1:0];
            endcase
            write_modulus(m);
            if (p == RANDOM_PHASES - 1)
                idle_on = 1'b0;

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Bases lean toward values around the modulus, where reduction matters.
                case ($urandom_range(0, 9))
                    6:       b = $urandom_range(0, 20);
                    7:       b = m - 1;
                    8:       b = m;
                    9:       b = m + 1;
                    default: b = $urandom;
                endcase
                // Exponents: many short ones keep the run fast, full-width ones reach
                // the top bits, and the all-zero and all-one patterns come up too.
                case ($urandom_range(0, 9))
                    5, 6, 7: e = $urandom_range(0, 64);
                    8:       e = 32'd1 << $urandom_range(0, W - 1);
                    9:       e = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                    default: e = $urandom;
                endcase
                input_gap();
                send_operands(b, e, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (expected_power_mod.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_power_mod.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_power_mod.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
